// ===== hw/rtl/gcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types and sizes for the centroid merge block: the input and output
// word layouts and the words passed between neighbouring cells.
// ----------------------------------------------------------------------------
package gcm_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int COORD_BITS   = 12;
	localparam int DIST_BITS    = 12;

	localparam int IDX_BITS   = $clog2(MAX_CLUSTERS);
	localparam int CNT_BITS   = $clog2(MAX_CLUSTERS + 1);
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int LIMIT_BITS = 2 * DIST_BITS;

	localparam logic [DIST_BITS-1:0]  DIST_RESET  = DIST_BITS'(30);
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET =
		LIMIT_BITS'(DIST_RESET) * LIMIT_BITS'(DIST_RESET);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [LIMIT_BITS-1:0] limit_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   starts_set;
		logic   ends_set;
	} point_word_t;

	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		logic   end_of_run;
		logic   points_dropped;
	} center_word_t;

	// point travelling down the chain
	typedef struct packed {
		logic   tok;
		coord_t x;
		coord_t y;
	} cell_fwd_t;

	// outcome of the scan so far, one cell behind the point
	typedef struct packed {
		logic tok;
		logic done;
		logic hit;
	} cell_res_t;

endpackage

// ===== hw/rtl/gcm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_cell
// One cluster slot of the chain. Squares the offsets to the passing point in
// its first stage, then merges, claims the slot or passes the outcome on.
// ----------------------------------------------------------------------------
module gcm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              occupied,
	input  gcm_pkg::limit_t   limit,
	input  gcm_pkg::cell_fwd_t fwd_in,
	input  gcm_pkg::cell_res_t res_in,
	output gcm_pkg::cell_fwd_t fwd_out,
	output gcm_pkg::cell_res_t res_out,
	output gcm_pkg::coord_t   center_x,
	output gcm_pkg::coord_t   center_y
);
	import gcm_pkg::*;

	coord_t              cx_q, cy_q;
	logic                tok_s1;
	coord_t              px_s1, py_s1;
	logic [SQ_BITS-1:0]  sqx_s1, sqy_s1;
	cell_res_t           res_q;

	coord_t              dx, dy;
	logic [SUM_BITS-1:0] dist_sq;
	logic                near, hit, place;
	logic [COORD_BITS:0] sum_x, sum_y;

	assign dx = (cx_q > fwd_in.x) ? cx_q - fwd_in.x : fwd_in.x - cx_q;
	assign dy = (cy_q > fwd_in.y) ? cy_q - fwd_in.y : fwd_in.y - cy_q;

	assign dist_sq = SUM_BITS'(sqx_s1) + SUM_BITS'(sqy_s1);
	assign near    = dist_sq < SUM_BITS'(limit);
	assign hit     = occupied && !res_in.done && near;
	assign place   = !occupied && !res_in.done;

	assign sum_x = {1'b0, cx_q} + {1'b0, px_s1};
	assign sum_y = {1'b0, cy_q} + {1'b0, py_s1};

	// stage 1: squared offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= 1'b0;
		end else begin
			tok_s1 <= fwd_in.tok;
		end
	end

	always_ff @(posedge clk) begin
		if (fwd_in.tok) begin
			px_s1  <= fwd_in.x;
			py_s1  <= fwd_in.y;
			sqx_s1 <= SQ_BITS'(dx) * SQ_BITS'(dx);
			sqy_s1 <= SQ_BITS'(dy) * SQ_BITS'(dy);
		end
	end

	// stage 2: decision and slot update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q.tok  <= tok_s1;
			res_q.done <= res_in.done | hit | place;
			res_q.hit  <= res_in.hit | hit;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_s1) begin
			if (hit) begin
				cx_q <= sum_x[COORD_BITS:1];
				cy_q <= sum_y[COORD_BITS:1];
			end else if (place) begin
				cx_q <= px_s1;
				cy_q <= py_s1;
			end
		end
	end

	assign fwd_out  = '{tok: tok_s1, x: px_s1, y: py_s1};
	assign res_out  = res_q;
	assign center_x = cx_q;
	assign center_y = cy_q;

endmodule

// ===== hw/rtl/greedy_centroid_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_centroid_merge
// Leader clustering of pixel points against a row of cluster cells, with
// one result word per stored center when a set ends.
// ----------------------------------------------------------------------------
//  channel   handshake                    word
//  point     point_valid / point_ready    point_word_t
//  center    center_valid / center_ready  center_word_t
//  config    wr_en                        wr_data (merge distance)
//
//  a point walks the cell row one cell per cycle; ready returns once
//  its outcome has left the last cell, so only one point is in the
//  row at a time
//  an ending point then emits one center per cycle unless the output stalls
//  the last center may wait in the output register while the next point
//  is taken
//  reset clears the table count, drop flag and sets the distance to 30
// ----------------------------------------------------------------------------
module greedy_centroid_merge (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   point_valid,
	output logic                   point_ready,
	input  gcm_pkg::point_word_t   point,
	output logic                   center_valid,
	input  logic                   center_ready,
	output gcm_pkg::center_word_t  center,
	input  logic                   wr_en,
	input  logic [gcm_pkg::DIST_BITS-1:0] wr_data
);
	import gcm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                state_q;
	limit_t                limit_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  ovf_q;
	logic                  ends_q;
	logic                  inj_q;
	coord_t                px_q, py_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic                  out_valid_q;
	center_word_t          out_q;

	cell_fwd_t             fwd [MAX_CLUSTERS+1];
	cell_res_t             res [MAX_CLUSTERS+1];
	coord_t                cell_x [MAX_CLUSTERS];
	coord_t                cell_y [MAX_CLUSTERS];

	logic                  take_point;
	logic                  load_out;
	logic                  last_idx;

	assign point_ready  = (state_q == ST_IDLE);
	assign take_point   = point_valid && point_ready;
	assign load_out     = (state_q == ST_EMIT) && (!out_valid_q || center_ready);
	assign last_idx     = (CNT_BITS'(idx_q) + CNT_BITS'(1)) == count_q;
	assign center_valid = out_valid_q;
	assign center       = out_q;

	assign fwd[0] = '{tok: inj_q, x: px_q, y: py_q};
	assign res[0] = '0;

	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		gcm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.occupied (CNT_BITS'(i) < count_q),
			.limit    (limit_q),
			.fwd_in   (fwd[i]),
			.res_in   (res[i]),
			.fwd_out  (fwd[i+1]),
			.res_out  (res[i+1]),
			.center_x (cell_x[i]),
			.center_y (cell_y[i])
		);
	end

	// threshold kept squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			limit_q <= LIMIT_BITS'(wr_data) * LIMIT_BITS'(wr_data);
		end
	end

	always_ff @(posedge clk) begin
		if (take_point) begin
			px_q   <= point.point_x;
			py_q   <= point.point_y;
			ends_q <= point.ends_set;
		end
		if (load_out) begin
			out_q.center_x       <= cell_x[idx_q];
			out_q.center_y       <= cell_y[idx_q];
			out_q.end_of_run     <= last_idx;
			out_q.points_dropped <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			inj_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			inj_q <= take_point;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (center_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take_point) begin
						if (point.starts_set) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (res[MAX_CLUSTERS].tok) begin
						if (!res[MAX_CLUSTERS].done) begin
							ovf_q <= 1'b1;
						end else if (!res[MAX_CLUSTERS].hit) begin
							count_q <= count_q + CNT_BITS'(1);
						end
						idx_q   <= '0;
						state_q <= ends_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						idx_q <= idx_q + IDX_BITS'(1);
						if (last_idx) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/gcm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_checker
// Port-level checks on the centroid merge block, bound to the top level.
// ----------------------------------------------------------------------------
module gcm_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  point_valid,
	input logic                  point_ready,
	input logic                  center_valid,
	input logic                  center_ready,
	input gcm_pkg::center_word_t center
);
	import gcm_pkg::*;

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		center_valid && !center_ready |=> center_valid && $stable(center))
		else $error("center word changed while stalled");

	// one point at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready |=> !point_ready)
		else $error("point taken while scan in progress");

	// a run continues until its last center
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		center_valid && center_ready && !center.end_of_run |=> center_valid)
		else $error("gap inside an emission");

	// no new point before the last center is out
	a_no_take_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		center_valid && !center.end_of_run |-> !point_ready)
		else $error("ready during an emission");

endmodule

bind greedy_centroid_merge gcm_checker u_gcm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_valid  (point_valid),
	.point_ready  (point_ready),
	.center_valid (center_valid),
	.center_ready (center_ready),
	.center       (center)
);
